/* rtl/button_scan_autorepeat_display_sleep_macros.svh */
// Assertion macros shared by the button scanner RTL.
`ifndef BUTTON_SCAN_AUTOREPEAT_DISPLAY_SLEEP_MACROS_SVH
`define BUTTON_SCAN_AUTOREPEAT_DISPLAY_SLEEP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bsad assertion failed");

// Next-cycle implication, checked outside reset.
`define BSAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bsad assertion failed");

`endif

/* rtl/bsad_pkg.sv */
// Package with shared types and constants of the button scanner.
`timescale 1ns / 1ps

package bsad_pkg;

    localparam int NOW_W     = 32;
    localparam int BTN_W     = 6;
    localparam int DTO_W     = 20;
    localparam int START_W   = 16;
    localparam int STEP_W    = 8;
    localparam int COUNT_W   = 6;
    localparam int POLL_W    = 16;
    localparam int FLAG_W    = 2;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CUT_W     = COUNT_W + STEP_W;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    localparam logic [FLAG_W-1:0] FLAG_FRESH    = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_CONSUMED = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_ARMED    = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AWAKE_POLL      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ASLEEP_POLL     = 3'd5;

    localparam logic [DTO_W-1:0]   RST_DISPLAY_TIMEOUT = 20'd20000;
    localparam logic [START_W-1:0] RST_REPEAT_START    = 16'd240;
    localparam logic [STEP_W-1:0]  RST_REPEAT_STEP     = 8'd4;
    localparam logic [COUNT_W-1:0] RST_RAMP_LIMIT      = 6'd60;
    localparam logic [POLL_W-1:0]  RST_AWAKE_POLL      = 16'd20;
    localparam logic [POLL_W-1:0]  RST_ASLEEP_POLL     = 16'd250;

    typedef struct packed {
        logic               held;
        logic [FLAG_W-1:0]  flag;
        logic [COUNT_W-1:0] count;
    } t_btn_ctl;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [STEP_W-1:0]  step;
        logic [COUNT_W-1:0] ramp;
    } t_rep_cfg;

endpackage

/* rtl/bsad_in_if.sv */
// Channel interface for scan and acknowledge items.
`timescale 1ns / 1ps

interface bsad_in_if
    import bsad_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             command;
    logic [NOW_W-1:0] now_ms;
    logic [BTN_W-1:0] button_bits;
    logic [BTN_W-1:0] ack_mask;
    logic             link_active;

    modport source (
        output valid, command, now_ms, button_bits, ack_mask, link_active,
        input  ready
    );
    modport sink (
        input  valid, command, now_ms, button_bits, ack_mask, link_active,
        output ready
    );
endinterface

/* rtl/bsad_out_if.sv */
// Channel interface for result items.
`timescale 1ns / 1ps

interface bsad_out_if
    import bsad_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BTN_W-1:0]  held_mask;
    logic [BTN_W-1:0]  fresh_mask;
    logic              display_on;
    logic              display_changed;
    logic [POLL_W-1:0] poll_interval_ms;

    modport source (
        output valid, held_mask, fresh_mask, display_on, display_changed, poll_interval_ms,
        input  ready
    );
    modport sink (
        input  valid, held_mask, fresh_mask, display_on, display_changed, poll_interval_ms,
        output ready
    );
endinterface

/* rtl/bsad_button.sv */
// Next-state logic of one button: press capture, auto-repeat, release and acknowledge.
`timescale 1ns / 1ps

module bsad_button
    import bsad_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_command,
    input  logic                  i_pressed,
    input  logic                  i_ack,
    input  logic [TIME_WIDTH-1:0] i_now,
    input  t_btn_ctl              i_ctl,
    input  logic [TIME_WIDTH-1:0] i_time,
    input  t_rep_cfg              i_cfg,
    output t_btn_ctl              o_ctl,
    output logic [TIME_WIDTH-1:0] o_time
);

    logic [COUNT_W-1:0]    w_used;
    logic [CUT_W-1:0]      w_cut;
    logic [START_W-1:0]    w_delay;
    logic [TIME_WIDTH-1:0] w_due;

    always_comb begin
        w_used  = (i_ctl.count > i_cfg.ramp) ? i_cfg.ramp : i_ctl.count;
        w_cut   = CUT_W'(w_used) * CUT_W'(i_cfg.step);
        w_delay = (i_cfg.start >= START_W'(w_cut)) ? (i_cfg.start - START_W'(w_cut))
                                                   : '0;
        w_due   = i_time + TIME_WIDTH'(w_delay);
    end

    always_comb begin
        o_ctl  = i_ctl;
        o_time = i_time;
        case (i_command)
            CMD_ACK: begin
                if (i_ack && i_ctl.held && i_ctl.flag == FLAG_FRESH) begin
                    o_ctl.flag = FLAG_CONSUMED;
                end
            end
            CMD_SCAN: begin
                if (i_pressed) begin
                    if (!i_ctl.held) begin
                        o_ctl.held  = 1'b1;
                        o_ctl.count = '0;
                        o_time      = i_now;
                    end else if (i_ctl.flag == FLAG_CONSUMED) begin
                        // The count advances each check, due or not, until saturated.
                        if (i_ctl.count <= i_cfg.ramp && i_ctl.count != COUNT_MAX) begin
                            o_ctl.count = i_ctl.count + COUNT_W'(1);
                        end
                        if (w_due < i_now) begin
                            o_time     = i_now;
                            o_ctl.flag = FLAG_FRESH;
                        end
                    end
                end else if (i_ctl.held) begin
                    o_ctl.flag  = (i_ctl.flag == FLAG_ARMED) ? FLAG_CONSUMED : FLAG_FRESH;
                    o_ctl.count = '0;
                    o_ctl.held  = 1'b0;
                    o_time      = '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/button_scan_autorepeat_display_sleep.sv */
// Top level of the button scanner with accelerating auto-repeat and display sleep.
//
// The block takes one item per clock cycle while the result side drains, and returns one result
// item for each: the item is captured in an input register, all buttons and the display logic
// update in parallel when it advances, and the result lands in an output register. The path
// between those registers holds one small repeat-delay multiply followed by a time add and
// compare per button. A stalled result holds the input register, and the input side keeps
// accepting as long as the result register can drain.
`timescale 1ns / 1ps

module button_scan_autorepeat_display_sleep
    import bsad_pkg::*;
#(
    parameter int NUM_BUTTONS = 6,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    bsad_in_if.sink               i_item,
    bsad_out_if.source            o_result
);

`include "button_scan_autorepeat_display_sleep_macros.svh"

    localparam int LAST  = NUM_BUTTONS - 1;
    localparam int NLIVE = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

    logic [DTO_W-1:0]   r_cfg_timeout;
    t_rep_cfg           r_cfg_rep;
    logic [POLL_W-1:0]  r_cfg_awake;
    logic [POLL_W-1:0]  r_cfg_asleep;

    logic               r_in_vld;
    logic               r_cmd;
    logic [NOW_W-1:0]   r_now;
    logic [BTN_W-1:0]   r_bits;
    logic [BTN_W-1:0]   r_mask;
    logic               r_usb;

    t_btn_ctl              r_ctl  [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0] r_time [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0] r_deadline;
    logic                  r_disp;

    logic               r_out_vld;
    logic [BTN_W-1:0]   r_res_held;
    logic [BTN_W-1:0]   r_res_fresh;
    logic               r_res_disp;
    logic               r_res_changed;
    logic [POLL_W-1:0]  r_res_poll;

    t_btn_ctl              n_ctl  [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0] n_time [NUM_BUTTONS];
    logic [TIME_WIDTH-1:0] n_deadline;
    logic                  n_disp;
    logic [BTN_W-1:0]      n_held;
    logic [BTN_W-1:0]      n_fresh;

    t_btn_ctl              w_ctl  [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] w_pressed;
    logic [NUM_BUTTONS-1:0] w_ack;
    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_extend;
    logic [TIME_WIDTH-1:0] w_deadline_a;
    logic                  w_scan;
    logic                  w_toggle;
    logic                  w_adv;
    logic                  w_in_fire;

    assign w_adv     = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_item.ready = !r_in_vld || w_adv;
    assign w_in_fire = i_item.valid && i_item.ready;

    assign w_scan   = (r_cmd == CMD_SCAN);
    assign w_now    = TIME_WIDTH'(r_now);
    assign w_extend = w_now + TIME_WIDTH'(r_cfg_timeout);

    always_comb begin
        w_pressed = '0;
        w_ack     = '0;
        for (int b = 0; b < NLIVE; b++) begin
            w_pressed[b] = r_bits[b];
            w_ack[b]     = r_mask[b];
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        bsad_button #(
            .TIME_WIDTH(TIME_WIDTH)
        ) u_button (
            .i_command(r_cmd),
            .i_pressed(w_pressed[g]),
            .i_ack    (w_ack[g]),
            .i_now    (w_now),
            .i_ctl    (r_ctl[g]),
            .i_time   (r_time[g]),
            .i_cfg    (r_cfg_rep),
            .o_ctl    (w_ctl[g]),
            .o_time   (n_time[g])
        );
    end

    always_comb begin
        w_deadline_a = (w_scan && (|w_pressed)) ? w_extend : r_deadline;
        w_toggle = w_scan && ((!w_ctl[LAST].held && w_ctl[LAST].flag == FLAG_FRESH) ||
                              (r_disp && w_deadline_a < w_now));
        n_disp     = r_disp ^ w_toggle;
        n_deadline = (w_scan && n_disp && r_usb) ? w_extend : w_deadline_a;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            n_ctl[b] = w_ctl[b];
        end
        if (w_toggle) begin
            n_ctl[LAST].flag = FLAG_CONSUMED;
        end
        n_held  = '0;
        n_fresh = '0;
        for (int b = 0; b < NLIVE; b++) begin
            n_held[b]  = n_ctl[b].held;
            n_fresh[b] = n_ctl[b].held && n_ctl[b].flag == FLAG_FRESH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_timeout   <= RST_DISPLAY_TIMEOUT;
            r_cfg_rep.start <= RST_REPEAT_START;
            r_cfg_rep.step  <= RST_REPEAT_STEP;
            r_cfg_rep.ramp  <= RST_RAMP_LIMIT;
            r_cfg_awake     <= RST_AWAKE_POLL;
            r_cfg_asleep    <= RST_ASLEEP_POLL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DISPLAY_TIMEOUT: r_cfg_timeout   <= i_cfg_data[DTO_W-1:0];
                REG_REPEAT_START:    r_cfg_rep.start <= i_cfg_data[START_W-1:0];
                REG_REPEAT_STEP:     r_cfg_rep.step  <= i_cfg_data[STEP_W-1:0];
                REG_RAMP_LIMIT:      r_cfg_rep.ramp  <= i_cfg_data[COUNT_W-1:0];
                REG_AWAKE_POLL:      r_cfg_awake     <= i_cfg_data[POLL_W-1:0];
                REG_ASLEEP_POLL:     r_cfg_asleep    <= i_cfg_data[POLL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_in_vld <= i_item.valid;
        end
        if (w_in_fire) begin
            r_cmd  <= i_item.command;
            r_now  <= i_item.now_ms;
            r_bits <= i_item.button_bits;
            r_mask <= i_item.ack_mask;
            r_usb  <= i_item.link_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_ctl[b].held  <= 1'b0;
                r_ctl[b].count <= '0;
                r_ctl[b].flag  <= (b == LAST) ? FLAG_ARMED : FLAG_FRESH;
            end
            r_deadline <= '0;
            r_disp     <= 1'b1;
        end else if (w_adv) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_ctl[b] <= n_ctl[b];
            end
            r_deadline <= n_deadline;
            r_disp     <= n_disp;
        end
        if (w_adv) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_time[b] <= n_time[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_adv) begin
            r_res_held    <= n_held;
            r_res_fresh   <= n_fresh;
            r_res_disp    <= n_disp;
            r_res_changed <= w_toggle;
            r_res_poll    <= n_disp ? r_cfg_awake : r_cfg_asleep;
        end
    end

    assign o_result.valid            = r_out_vld;
    assign o_result.held_mask        = r_res_held;
    assign o_result.fresh_mask       = r_res_fresh;
    assign o_result.display_on       = r_res_disp;
    assign o_result.display_changed  = r_res_changed;
    assign o_result.poll_interval_ms = r_res_poll;

    `BSAD_ASSERT_NOW(a_fresh_in_held, i_clk, i_rst_n, r_out_vld,
        (r_res_fresh & ~r_res_held) == '0)
    `BSAD_ASSERT_NEXT(a_toggle_flips, i_clk, i_rst_n, w_adv && w_toggle,
        r_disp != $past(r_disp))
    `BSAD_ASSERT_NEXT(a_ack_keeps_disp, i_clk, i_rst_n, w_adv && r_cmd == CMD_ACK,
        $stable(r_disp) && $stable(r_deadline))
    `BSAD_ASSERT_NEXT(a_item_kept, i_clk, i_rst_n, r_in_vld && !w_adv,
        r_in_vld && $stable(r_now) && $stable(r_cmd))

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the button scanner with auto-repeat and display sleep.
`timescale 1ns / 1ps

module tb_top;
    import bsad_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int LAST_BTN = BTN_W - 1;

    typedef struct packed {
        logic [BTN_W-1:0]  held_mask;
        logic [BTN_W-1:0]  fresh_mask;
        logic              display_on;
        logic              display_changed;
        logic [POLL_W-1:0] poll_interval_ms;
    } t_scan_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bsad_in_if  item_ch ();
    bsad_out_if result_ch ();

    button_scan_autorepeat_display_sleep dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    // Keypad state and register copies used to work out each expected result.
    logic [BTN_W-1:0]   kp_held;
    logic [NOW_W-1:0]   kp_press_time [BTN_W];
    logic [COUNT_W-1:0] kp_count [BTN_W];
    logic [FLAG_W-1:0]  kp_flag [BTN_W];
    logic [NOW_W-1:0]   kp_deadline;
    logic               kp_display;
    logic [DTO_W-1:0]   cfg_timeout;
    t_rep_cfg           cfg_rep;
    logic [POLL_W-1:0]  cfg_awake;
    logic [POLL_W-1:0]  cfg_asleep;

    t_scan_result pending_results [$];
    int mismatch_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    logic [NOW_W-1:0] cur_ms = '0;
    logic [BTN_W-1:0] pad_bits = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void reset_keypad();
        kp_held = '0;
        for (int b = 0; b < BTN_W; b++) begin
            kp_press_time[b] = '0;
            kp_count[b] = '0;
            kp_flag[b] = FLAG_FRESH;
        end
        kp_flag[LAST_BTN] = FLAG_ARMED;
        kp_deadline = '0;
        kp_display = 1'b1;
        cfg_timeout = RST_DISPLAY_TIMEOUT;
        cfg_rep.start = RST_REPEAT_START;
        cfg_rep.step = RST_REPEAT_STEP;
        cfg_rep.ramp = RST_RAMP_LIMIT;
        cfg_awake = RST_AWAKE_POLL;
        cfg_asleep = RST_ASLEEP_POLL;
    endfunction

    function automatic t_scan_result advance_keypad(logic cmd, logic [NOW_W-1:0] now,
                                                    logic [BTN_W-1:0] bits,
                                                    logic [BTN_W-1:0] mask, logic usb);
        t_scan_result r;
        logic [COUNT_W-1:0] used;
        logic [START_W-1:0] cut;
        logic [START_W-1:0] delay;
        logic [NOW_W-1:0] due;
        logic toggled;
        toggled = 1'b0;
        if (cmd == CMD_ACK) begin
            for (int b = 0; b < BTN_W; b++) begin
                if (mask[b] && kp_held[b] && kp_flag[b] == FLAG_FRESH) begin
                    kp_flag[b] = FLAG_CONSUMED;
                end
            end
        end else begin
            for (int b = 0; b < BTN_W; b++) begin
                if (bits[b]) begin
                    if (!kp_held[b]) begin
                        kp_held[b] = 1'b1;
                        kp_press_time[b] = now;
                        kp_count[b] = '0;
                    end else if (kp_flag[b] == FLAG_CONSUMED) begin
                        used = (kp_count[b] > cfg_rep.ramp) ? cfg_rep.ramp : kp_count[b];
                        cut = START_W'(used) * START_W'(cfg_rep.step);
                        if (kp_count[b] <= cfg_rep.ramp && kp_count[b] != COUNT_MAX) begin
                            kp_count[b] = kp_count[b] + 1'b1;
                        end
                        delay = (cfg_rep.start >= cut) ? cfg_rep.start - cut : '0;
                        due = kp_press_time[b] + NOW_W'(delay);
                        if (due < now) begin
                            kp_press_time[b] = now;
                            kp_flag[b] = FLAG_FRESH;
                        end
                    end
                    kp_deadline = now + NOW_W'(cfg_timeout);
                end else if (kp_held[b]) begin
                    kp_flag[b] = (kp_flag[b] == FLAG_ARMED) ? FLAG_CONSUMED : FLAG_FRESH;
                    kp_count[b] = '0;
                    kp_press_time[b] = '0;
                    kp_held[b] = 1'b0;
                end
            end
            if ((!kp_held[LAST_BTN] && kp_flag[LAST_BTN] == FLAG_FRESH) ||
                (kp_display && kp_deadline < now)) begin
                kp_display = ~kp_display;
                kp_flag[LAST_BTN] = FLAG_CONSUMED;
                toggled = 1'b1;
            end
            if (kp_display && usb) begin
                kp_deadline = now + NOW_W'(cfg_timeout);
            end
        end
        r.held_mask = kp_held;
        for (int b = 0; b < BTN_W; b++) begin
            r.fresh_mask[b] = kp_held[b] && kp_flag[b] == FLAG_FRESH;
        end
        r.display_on = kp_display;
        r.display_changed = toggled;
        r.poll_interval_ms = kp_display ? cfg_awake : cfg_asleep;
        return r;
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result item, expected none actual %0h", $time,
                         result_ch.held_mask);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("held_mask", want.held_mask, result_ch.held_mask);
                report_field("fresh_mask", want.fresh_mask, result_ch.fresh_mask);
                report_field("display_on", want.display_on, result_ch.display_on);
                report_field("display_changed", want.display_changed,
                             result_ch.display_changed);
                report_field("poll_interval_ms", want.poll_interval_ms,
                             result_ch.poll_interval_ms);
            end
        end
    end

    task automatic send_item(logic cmd, logic [NOW_W-1:0] now, logic [BTN_W-1:0] bits,
                             logic [BTN_W-1:0] mask, logic usb);
        while ($urandom_range(0, 99) < idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.command <= cmd;
        item_ch.now_ms <= now;
        item_ch.button_bits <= bits;
        item_ch.ack_mask <= mask;
        item_ch.link_active <= usb;
        do @(posedge i_clk); while (!item_ch.ready);
        pending_results.push_back(advance_keypad(cmd, now, bits, mask, usb));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        case (idx)
            REG_DISPLAY_TIMEOUT: cfg_timeout = data[DTO_W-1:0];
            REG_REPEAT_START:    cfg_rep.start = data[START_W-1:0];
            REG_REPEAT_STEP:     cfg_rep.step = data[STEP_W-1:0];
            REG_RAMP_LIMIT:      cfg_rep.ramp = data[COUNT_W-1:0];
            REG_AWAKE_POLL:      cfg_awake = data[POLL_W-1:0];
            REG_ASLEEP_POLL:     cfg_asleep = data[POLL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [DTO_W-1:0] timeout, logic [START_W-1:0] start,
                              logic [STEP_W-1:0] step, logic [COUNT_W-1:0] ramp,
                              logic [POLL_W-1:0] awake, logic [POLL_W-1:0] asleep);
        wait_drained();
        write_reg(REG_DISPLAY_TIMEOUT, CFG_DATA_W'(timeout));
        write_reg(REG_REPEAT_START, CFG_DATA_W'(start));
        write_reg(REG_REPEAT_STEP, CFG_DATA_W'(step));
        write_reg(REG_RAMP_LIMIT, CFG_DATA_W'(ramp));
        write_reg(REG_AWAKE_POLL, CFG_DATA_W'(awake));
        write_reg(REG_ASLEEP_POLL, CFG_DATA_W'(asleep));
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Buttons mostly stay as they are, so held and consumed presses reach the repeat logic.
    task automatic run_traffic(int count, int flip_pct);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                cur_ms = cur_ms + $urandom_range(0, 30);
            end else if (r < 90) begin
                cur_ms = cur_ms + $urandom_range(31, 500);
            end else if (r < 98) begin
                cur_ms = cur_ms + $urandom_range(501, 50000);
            end else begin
                cur_ms = $urandom;
            end
            if ($urandom_range(0, 99) < 3) begin
                pad_bits = BTN_W'($urandom);
            end else begin
                for (int b = 0; b < BTN_W; b++) begin
                    if ($urandom_range(0, 99) < flip_pct) pad_bits[b] = ~pad_bits[b];
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                send_item(CMD_ACK, $urandom, BTN_W'($urandom),
                          $urandom_range(0, 1) ? pad_bits : BTN_W'($urandom),
                          1'($urandom));
            end else begin
                send_item(CMD_SCAN, cur_ms, pad_bits, BTN_W'($urandom),
                          1'($urandom_range(0, 3) == 0));
            end
        end
    endtask

    task automatic test_directed_sequence();
        idle_pct = 0;
        stall_pct = 0;
        send_item(CMD_SCAN, 32'd0, 6'h00, 6'h00, 1'b0);
        send_item(CMD_SCAN, 32'd0, 6'h3F, 6'h00, 1'b0);
        send_item(CMD_ACK, 32'd0, 6'h00, 6'h15, 1'b0);
        send_item(CMD_ACK, 32'd0, 6'h00, 6'h3F, 1'b0);
        send_item(CMD_SCAN, 32'd100, 6'h3F, 6'h00, 1'b0);
        send_item(CMD_SCAN, 32'd300, 6'h3F, 6'h00, 1'b1);
        send_item(CMD_SCAN, 32'd301, 6'h00, 6'h3F, 1'b0);
        send_item(CMD_SCAN, 32'd400, 6'h20, 6'h00, 1'b0);
        send_item(CMD_SCAN, 32'd401, 6'h00, 6'h00, 1'b0);
        send_item(CMD_SCAN, 32'd30000, 6'h00, 6'h00, 1'b0);
        send_item(CMD_SCAN, 32'd40000, 6'h00, 6'h00, 1'b1);
        send_item(CMD_ACK, 32'hFFFFFFFF, 6'h3F, 6'h3F, 1'b1);
        send_item(CMD_SCAN, 32'hFFFFFFF0, 6'h2A, 6'h00, 1'b0);
        send_item(CMD_ACK, 32'd0, 6'h00, 6'h2A, 1'b0);
        send_item(CMD_SCAN, 32'hFFFFFFFF, 6'h2A, 6'h00, 1'b1);
        send_item(CMD_SCAN, 32'hFFFFFFFF, 6'h15, 6'h00, 1'b1);
        send_item(CMD_SCAN, 32'd5, 6'h00, 6'h00, 1'b0);
        send_item(CMD_SCAN, 32'd50000, 6'h20, 6'h00, 1'b0);
        send_item(CMD_ACK, 32'd0, 6'h00, 6'h20, 1'b0);
        send_item(CMD_SCAN, 32'd50001, 6'h00, 6'h00, 1'b0);
        cur_ms = 32'd50001;
    endtask

    task automatic test_random_default_setting();
        set_config(RST_DISPLAY_TIMEOUT, RST_REPEAT_START, RST_REPEAT_STEP, RST_RAMP_LIMIT,
                   RST_AWAKE_POLL, RST_ASLEEP_POLL);
        idle_pct = 0;
        stall_pct = 0;
        run_traffic(150, 10);
    endtask

    task automatic test_instant_sleep_long_repeat();
        set_config(20'd0, 16'd65535, 8'd255, 6'd63, 16'd1, 16'd65535);
        idle_pct = 84;
        stall_pct = 0;
        run_traffic(130, 2);
    endtask

    task automatic test_long_timeout_zero_polls();
        set_config(20'd1000000, 16'd0, 8'd0, 6'd0, 16'd0, 16'd0);
        idle_pct = 0;
        stall_pct = 84;
        run_traffic(110, 8);
    endtask

    task automatic test_clamped_repeat_both_idle();
        set_config(20'd50, 16'd100, 8'd30, 6'd20, 16'd65535, 16'd1);
        idle_pct = 32;
        stall_pct = 32;
        run_traffic(110, 15);
    endtask

    task automatic test_random_settings();
        set_config(DTO_W'($urandom_range(0, 1000000)), START_W'($urandom),
                   STEP_W'($urandom), COUNT_W'($urandom),
                   POLL_W'($urandom_range(1, 65535)), POLL_W'($urandom_range(1, 65535)));
        idle_pct = 0;
        stall_pct = 0;
        run_traffic(100, 5);
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.command = CMD_SCAN;
        item_ch.now_ms = '0;
        item_ch.button_bits = '0;
        item_ch.ack_mask = '0;
        item_ch.link_active = 1'b0;
        reset_keypad();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_sequence();
        test_random_default_setting();
        test_instant_sleep_long_repeat();
        test_long_timeout_zero_polls();
        test_clamped_repeat_both_idle();
        test_random_settings();

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
